>>> rtl/core/npp_pkg.sv
// Package: widths, sequencer states and shared types of the nearest primitive pick.
`timescale 1ns / 1ps
package npp_pkg;

	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;
	localparam int INDEX_BITS  = 16;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int OP_W   = (COORD_BITS + 3 > T_FRAC_BITS + 2) ? COORD_BITS + 3
	                                                           : T_FRAC_BITS + 2;
	localparam int PROD_W = 2 * OP_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int LEN_W  = 2 * DIFF_W;
	localparam int BEST_W = 2 * COORD_BITS;
	localparam int T_W    = T_FRAC_BITS + 1;
	localparam int DCNT_W = $clog2(T_FRAC_BITS + 1);

	localparam logic [COORD_BITS-1:0] THR_RESET = COORD_BITS'(160);
	localparam logic [T_W-1:0]        T_ONE     = T_W'(1) << T_FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_THR,
		S_BEST,
		S_LEN_X,
		S_LEN_Y,
		S_DOT_X,
		S_DOT_Y,
		S_CLASS,
		S_DIV,
		S_OFF_X,
		S_OFF_Y,
		S_OFF_END,
		S_DST_X,
		S_DST_Y,
		S_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/core/npp_in_if.sv
// Interface: primitive input channel.
`timescale 1ns / 1ps
interface npp_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [npp_pkg::COORD_BITS-1:0] query_x;
	logic signed [npp_pkg::COORD_BITS-1:0] query_y;
	logic                                 is_segment;
	logic                                 on_series_layer;
	logic signed [npp_pkg::INDEX_BITS-1:0] data_index;
	logic signed [npp_pkg::COORD_BITS-1:0] ax;
	logic signed [npp_pkg::COORD_BITS-1:0] ay;
	logic signed [npp_pkg::COORD_BITS-1:0] bx;
	logic signed [npp_pkg::COORD_BITS-1:0] by;
	logic                                 end_of_list;

	modport source (output valid, query_x, query_y, is_segment, on_series_layer, data_index,
		ax, ay, bx, by, end_of_list, input ready);
	modport sink (input valid, query_x, query_y, is_segment, on_series_layer, data_index,
		ax, ay, bx, by, end_of_list, output ready);
endinterface

>>> rtl/core/npp_out_if.sv
// Interface: pick result channel.
`timescale 1ns / 1ps
interface npp_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 hit;
	logic signed [npp_pkg::INDEX_BITS-1:0] picked_index;

	modport source (output valid, hit, picked_index, input ready);
	modport sink (input valid, hit, picked_index, output ready);
endinterface

>>> rtl/core/npp_cfg_if.sv
// Interface: threshold register write channel.
`timescale 1ns / 1ps
interface npp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [npp_pkg::COORD_BITS-1:0] max_distance;

	modport source (output valid, max_distance, input ready);
	modport sink (input valid, max_distance, output ready);
endinterface

>>> rtl/core/npp_mac.sv
// Shared signed multiply-accumulate unit.
`timescale 1ns / 1ps
module npp_mac (
	input  logic                                clk,
	input  npp_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [npp_pkg::OP_W-1:0]     op_a,
	input  logic signed [npp_pkg::OP_W-1:0]     op_b,
	output logic signed [npp_pkg::ACC_W-1:0]    acc
);
	logic signed [npp_pkg::PROD_W-1:0] prod;
	logic signed [npp_pkg::ACC_W-1:0]  acc_q;

	assign prod = op_a * op_b;
	assign acc  = acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= (ctrl.clr ? '0 : acc_q) + npp_pkg::ACC_W'(prod);
		end
	end
endmodule

>>> rtl/core/npp_div.sv
// Restoring divider, one quotient bit per cycle: floor(num * 2^T / den), num < den.
`timescale 1ns / 1ps
module npp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [npp_pkg::LEN_W-1:0]         num,
	input  logic [npp_pkg::LEN_W-1:0]         den,
	output npp_pkg::div_stat_t                stat,
	output logic [npp_pkg::T_FRAC_BITS-1:0]   quo
);
	logic [npp_pkg::LEN_W:0]            rem_q;
	logic [npp_pkg::LEN_W-1:0]          den_q;
	logic [npp_pkg::T_FRAC_BITS-1:0]    quo_q;
	logic [npp_pkg::DCNT_W-1:0]         cnt_q;
	logic                               busy_q;
	logic [npp_pkg::LEN_W:0]            rem_sh;
	logic                               ge;

	assign rem_sh    = {rem_q[npp_pkg::LEN_W-1:0], 1'b0};
	assign ge        = rem_sh >= {1'b0, den_q};
	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= npp_pkg::DCNT_W'(npp_pkg::T_FRAC_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[npp_pkg::T_FRAC_BITS-2:0], ge};
		end
	end
endmodule

>>> rtl/core/nearest_primitive_pick_top.sv
// Top level: sequencer and datapath of the nearest primitive pick.
`timescale 1ns / 1ps
// Usage:
//   prim   - one primitive per transaction (point or segment, index, layer flag,
//            query pixel, end_of_list marker). Ready only while the sequencer idles.
//   result - one transaction per search, after the primitive marked end_of_list:
//            hit and picked_index (-1 when nothing lay within the threshold).
//   cfg    - writes max_distance; always ready. Latched when a search starts.
// Steps per primitive, all on one shared 19x19 multiply-accumulate unit: a
//   skipped primitive is only compared; a point has its distance squared; a
//   segment forms its squared length and dot product, clamps t or divides for it
//   one bit per cycle, then offsets and squares the distance (a zero-length one
//   goes straight to the distance). A search's first primitive adds the threshold
//   square; the result register is loaded in the done step after the last one.
// A finished result waits in an output register; the next search's primitives
// are taken while it stalls. A second result waits until the first is taken.
// Reset clears the sequencer, empties the output and loads threshold 160 (10 px).
module nearest_primitive_pick_top (
	input  logic   clk,
	input  logic   arst_n,
	npp_in_if.sink   prim,
	npp_out_if.source result,
	npp_cfg_if.sink  cfg
);
	npp_pkg::state_t state_q, state_d;

	logic [npp_pkg::COORD_BITS-1:0]        thr_q;
	logic                                  start_q;
	logic [npp_pkg::BEST_W-1:0]            best_q;
	logic signed [npp_pkg::INDEX_BITS-1:0] best_idx_q;

	logic signed [npp_pkg::DIFF_W-1:0]     wx_q, wy_q, abx_q, aby_q;
	logic                                  seg_q, skip_q, last_q;
	logic signed [npp_pkg::INDEX_BITS-1:0] idx_q;
	logic [npp_pkg::LEN_W-1:0]             len2_q;
	logic [npp_pkg::T_W-1:0]               t_q;
	logic signed [npp_pkg::OP_W-1:0]       dx_q, dy_q;

	logic                                  res_valid_q, res_hit_q;
	logic signed [npp_pkg::INDEX_BITS-1:0] res_idx_q;

	npp_pkg::mac_ctrl_t                    mac_ctrl;
	logic signed [npp_pkg::OP_W-1:0]       op_a, op_b;
	logic signed [npp_pkg::ACC_W-1:0]      acc;
	npp_pkg::div_stat_t                    div_stat;
	logic [npp_pkg::T_FRAC_BITS-1:0]       div_quo;
	logic                                  div_start;

	logic                                  accept, in_skip;
	logic signed [npp_pkg::OP_W-1:0]       wx_e, wy_e, abx_e, aby_e, abx_m, aby_m, t_e;
	logic [npp_pkg::ACC_W-1:0]             acc_u, rnd;
	logic signed [npp_pkg::OP_W-1:0]       off_mag, off;
	logic                                  out_free;

	npp_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	npp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc[npp_pkg::LEN_W-1:0]),
		.den    (len2_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	function automatic npp_pkg::state_t dispatch(input logic skip, input logic seg);
		npp_pkg::state_t s;
		if (skip) begin
			s = npp_pkg::S_CMP;
		end else if (seg) begin
			s = npp_pkg::S_LEN_X;
		end else begin
			s = npp_pkg::S_DST_X;
		end
		return s;
	endfunction

	function automatic logic signed [npp_pkg::DIFF_W-1:0] DIFF_EXT(
		input logic signed [npp_pkg::COORD_BITS-1:0] v);
		return npp_pkg::DIFF_W'(v);
	endfunction

	assign accept    = prim.valid && prim.ready;
	assign in_skip   = !prim.on_series_layer || prim.data_index[npp_pkg::INDEX_BITS-1];
	assign out_free  = !res_valid_q || result.ready;
	assign cfg.ready = 1'b1;

	assign wx_e  = npp_pkg::OP_W'(wx_q);
	assign wy_e  = npp_pkg::OP_W'(wy_q);
	assign abx_e = npp_pkg::OP_W'(abx_q);
	assign aby_e = npp_pkg::OP_W'(aby_q);
	assign abx_m = abx_q[npp_pkg::DIFF_W-1] ? -abx_e : abx_e;
	assign aby_m = aby_q[npp_pkg::DIFF_W-1] ? -aby_e : aby_e;
	assign t_e   = npp_pkg::OP_W'({1'b0, t_q});

	// round to nearest, halves away from zero, on the magnitude
	assign acc_u   = acc;
	assign rnd     = acc_u + (npp_pkg::ACC_W'(1) << (npp_pkg::T_FRAC_BITS - 1));
	assign off_mag = rnd[npp_pkg::T_FRAC_BITS +: npp_pkg::OP_W];

	always_comb begin
		state_d = state_q;
		case (state_q)
			npp_pkg::S_IDLE: begin
				if (accept) begin
					state_d = start_q ? npp_pkg::S_THR : dispatch(in_skip, prim.is_segment);
				end
			end
			npp_pkg::S_THR:     state_d = npp_pkg::S_BEST;
			npp_pkg::S_BEST:    state_d = dispatch(skip_q, seg_q);
			npp_pkg::S_LEN_X:   state_d = npp_pkg::S_LEN_Y;
			npp_pkg::S_LEN_Y:   state_d = npp_pkg::S_DOT_X;
			npp_pkg::S_DOT_X:   state_d = npp_pkg::S_DOT_Y;
			npp_pkg::S_DOT_Y:   state_d = npp_pkg::S_CLASS;
			npp_pkg::S_CLASS: begin
				if (len2_q == '0) begin
					state_d = npp_pkg::S_DST_X;
				end else if (acc <= 0 || acc >= $signed({1'b0, len2_q})) begin
					state_d = npp_pkg::S_OFF_X;
				end else begin
					state_d = npp_pkg::S_DIV;
				end
			end
			npp_pkg::S_DIV: begin
				if (div_stat.done) begin
					state_d = npp_pkg::S_OFF_X;
				end
			end
			npp_pkg::S_OFF_X:   state_d = npp_pkg::S_OFF_Y;
			npp_pkg::S_OFF_Y:   state_d = npp_pkg::S_OFF_END;
			npp_pkg::S_OFF_END: state_d = npp_pkg::S_DST_X;
			npp_pkg::S_DST_X:   state_d = npp_pkg::S_DST_Y;
			npp_pkg::S_DST_Y:   state_d = npp_pkg::S_CMP;
			npp_pkg::S_CMP:     state_d = last_q ? npp_pkg::S_DONE : npp_pkg::S_IDLE;
			npp_pkg::S_DONE: begin
				if (out_free) begin
					state_d = npp_pkg::S_IDLE;
				end
			end
			default:            state_d = npp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		prim.ready   = (state_q == npp_pkg::S_IDLE);
		mac_ctrl.en  = 1'b1;
		mac_ctrl.clr = 1'b1;
		op_a         = '0;
		op_b         = '0;
		div_start    = 1'b0;
		case (state_q)
			npp_pkg::S_THR: begin
				op_a = npp_pkg::OP_W'({1'b0, thr_q});
				op_b = npp_pkg::OP_W'({1'b0, thr_q});
			end
			npp_pkg::S_LEN_X: begin
				op_a = abx_e;
				op_b = abx_e;
			end
			npp_pkg::S_LEN_Y: begin
				op_a         = aby_e;
				op_b         = aby_e;
				mac_ctrl.clr = 1'b0;
			end
			npp_pkg::S_DOT_X: begin
				op_a = wx_e;
				op_b = abx_e;
			end
			npp_pkg::S_DOT_Y: begin
				op_a         = wy_e;
				op_b         = aby_e;
				mac_ctrl.clr = 1'b0;
			end
			npp_pkg::S_CLASS: begin
				mac_ctrl.en = 1'b0;
				div_start   = (len2_q != '0) && (acc > 0) && (acc < $signed({1'b0, len2_q}));
			end
			npp_pkg::S_OFF_X: begin
				op_a = abx_m;
				op_b = t_e;
			end
			npp_pkg::S_OFF_Y: begin
				op_a = aby_m;
				op_b = t_e;
			end
			npp_pkg::S_DST_X: begin
				op_a = dx_q;
				op_b = dx_q;
			end
			npp_pkg::S_DST_Y: begin
				op_a         = dy_q;
				op_b         = dy_q;
				mac_ctrl.clr = 1'b0;
			end
			default: begin
				mac_ctrl.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= npp_pkg::S_IDLE;
			thr_q       <= npp_pkg::THR_RESET;
			start_q     <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				thr_q <= cfg.max_distance;
			end
			if (accept) begin
				start_q <= 1'b0;
			end
			if (state_q == npp_pkg::S_DONE && out_free) begin
				res_valid_q <= 1'b1;
				start_q     <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wx_q   <= DIFF_EXT(prim.query_x) - DIFF_EXT(prim.ax);
			wy_q   <= DIFF_EXT(prim.query_y) - DIFF_EXT(prim.ay);
			abx_q  <= DIFF_EXT(prim.bx) - DIFF_EXT(prim.ax);
			aby_q  <= DIFF_EXT(prim.by) - DIFF_EXT(prim.ay);
			seg_q  <= prim.is_segment;
			skip_q <= in_skip;
			last_q <= prim.end_of_list;
			idx_q  <= prim.data_index;
			dx_q   <= npp_pkg::OP_W'(DIFF_EXT(prim.query_x) - DIFF_EXT(prim.ax));
			dy_q   <= npp_pkg::OP_W'(DIFF_EXT(prim.query_y) - DIFF_EXT(prim.ay));
		end
		case (state_q)
			npp_pkg::S_BEST: begin
				best_q     <= acc_u[npp_pkg::BEST_W-1:0];
				best_idx_q <= '1;
			end
			npp_pkg::S_DOT_X: len2_q <= acc_u[npp_pkg::LEN_W-1:0];
			npp_pkg::S_CLASS: t_q <= (acc <= 0) ? '0 : npp_pkg::T_ONE;
			npp_pkg::S_DIV: begin
				if (div_stat.done) begin
					t_q <= {1'b0, div_quo};
				end
			end
			npp_pkg::S_OFF_Y:   dx_q <= wx_e - off;
			npp_pkg::S_OFF_END: dy_q <= wy_e - off;
			npp_pkg::S_CMP: begin
				if (!skip_q && acc_u < npp_pkg::ACC_W'(best_q)) begin
					best_q     <= acc_u[npp_pkg::BEST_W-1:0];
					best_idx_q <= idx_q;
				end
			end
			npp_pkg::S_DONE: begin
				if (out_free) begin
					res_hit_q <= !best_idx_q[npp_pkg::INDEX_BITS-1];
					res_idx_q <= best_idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	// signed offset of the current axis: x in S_OFF_Y, y in S_OFF_END
	always_comb begin
		if (state_q == npp_pkg::S_OFF_Y) begin
			off = abx_q[npp_pkg::DIFF_W-1] ? -off_mag : off_mag;
		end else begin
			off = aby_q[npp_pkg::DIFF_W-1] ? -off_mag : off_mag;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.hit          = res_hit_q;
	assign result.picked_index = res_idx_q;

	a_hit_matches_index: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.hit == !result.picked_index[npp_pkg::INDEX_BITS-1]))
		else $error("hit flag disagrees with picked index");

	a_div_only_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == npp_pkg::S_DIV))
		else $error("divider busy outside division step");

	a_one_transaction_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(prim.valid && prim.ready) |=> !prim.ready)
		else $error("input taken while a primitive is in work");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> ($past(state_q) == npp_pkg::S_DONE))
		else $error("result raised outside the done step");
endmodule

>>> sim/nearest_primitive_pick_top_test.sv
// Testbench: nearest primitive pick results checked against a fixed-point predictor.
`timescale 1ns / 1ps
module nearest_primitive_pick_top_test;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 7;
	localparam int IDLE_GAP = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 112;
	localparam int USE_MODEL = -2;

	typedef struct packed {
		logic signed [npp_pkg::COORD_BITS-1:0] query_x;
		logic signed [npp_pkg::COORD_BITS-1:0] query_y;
		logic                                  is_segment;
		logic                                  on_series_layer;
		logic signed [npp_pkg::INDEX_BITS-1:0] data_index;
		logic signed [npp_pkg::COORD_BITS-1:0] ax;
		logic signed [npp_pkg::COORD_BITS-1:0] ay;
		logic signed [npp_pkg::COORD_BITS-1:0] bx;
		logic signed [npp_pkg::COORD_BITS-1:0] by;
		logic                                  end_of_list;
	} prim_t;

	localparam int PRIM_W = $bits(prim_t);

	typedef struct packed {
		logic                                  hit;
		logic signed [npp_pkg::INDEX_BITS-1:0] idx;
	} pick_t;

	typedef struct {
		int    thr;
		prim_t p;
		int    want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_ready = 1'b0;
	logic [10:0] stall_pat = 11'h5a5;
	int cycles = 0;
	int mismatches = 0;
	int burst_left = 0;

	pick_t picks_due[$];
	pick_t want_pick;
	row_t script[$];

	logic [npp_pkg::COORD_BITS-1:0]        thr_now = npp_pkg::THR_RESET;
	longint unsigned                       best_d2 = 0;
	logic signed [npp_pkg::INDEX_BITS-1:0] best_idx = '1;
	bit                                    new_search = 1'b1;

	npp_in_if  prim_ch ();
	npp_out_if res_ch ();
	npp_cfg_if cfg_ch ();

	nearest_primitive_pick_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.prim   (prim_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	assign res_ch.ready = rx_ready;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic longint unsigned mag2(longint v);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		return m * m;
	endfunction

	// ab * t / 2^T rounded to nearest, halves away from zero
	function automatic longint proj_step(longint d, longint unsigned t);
		longint unsigned m, r;
		m = (d < 0) ? -d : d;
		r = (m * t + (64'd1 << (npp_pkg::T_FRAC_BITS - 1))) >> npp_pkg::T_FRAC_BITS;
		return (d < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned gap2(prim_t p);
		longint wx, wy, abx, aby, dot;
		longint unsigned len2, udot, t;
		wx = longint'($signed(p.query_x)) - longint'($signed(p.ax));
		wy = longint'($signed(p.query_y)) - longint'($signed(p.ay));
		if (!p.is_segment)
			return mag2(wx) + mag2(wy);
		abx = longint'($signed(p.bx)) - longint'($signed(p.ax));
		aby = longint'($signed(p.by)) - longint'($signed(p.ay));
		len2 = mag2(abx) + mag2(aby);
		if (len2 == 0)
			return mag2(wx) + mag2(wy);
		dot = wx * abx + wy * aby;
		udot = dot;
		if (dot <= 0)
			t = 0;
		else if (udot >= len2)
			t = 64'd1 << npp_pkg::T_FRAC_BITS;
		else
			t = (udot << npp_pkg::T_FRAC_BITS) / len2;
		return mag2(wx - proj_step(abx, t)) + mag2(wy - proj_step(aby, t));
	endfunction

	function automatic bit track_nearest(input prim_t p, output pick_t r);
		longint unsigned d;
		if (new_search) begin
			best_d2 = 64'(thr_now) * 64'(thr_now);
			best_idx = '1;
			new_search = 1'b0;
		end
		if (p.on_series_layer && !p.data_index[npp_pkg::INDEX_BITS-1]) begin
			d = gap2(p);
			if (d < best_d2) begin
				best_d2 = d;
				best_idx = p.data_index;
			end
		end
		r.hit = !best_idx[npp_pkg::INDEX_BITS-1];
		r.idx = best_idx;
		if (p.end_of_list)
			new_search = 1'b1;
		return p.end_of_list;
	endfunction

	function automatic logic [npp_pkg::COORD_BITS-1:0] near(int c, int span);
		return npp_pkg::COORD_BITS'(c + int'($urandom_range(2 * span)) - span);
	endfunction

	// want: USE_MODEL, -1 for a miss, else the index that must be picked
	function automatic void add_row(int thr, int qx, int qy, bit seg, bit lay, int idx,
		int ax, int ay, int bx, int by, bit last, int want);
		row_t r;
		r.thr = thr;
		r.p.query_x = npp_pkg::COORD_BITS'(qx);
		r.p.query_y = npp_pkg::COORD_BITS'(qy);
		r.p.is_segment = seg;
		r.p.on_series_layer = lay;
		r.p.data_index = npp_pkg::INDEX_BITS'(idx);
		r.p.ax = npp_pkg::COORD_BITS'(ax);
		r.p.ay = npp_pkg::COORD_BITS'(ay);
		r.p.bx = npp_pkg::COORD_BITS'(bx);
		r.p.by = npp_pkg::COORD_BITS'(by);
		r.p.end_of_list = last;
		r.want = want;
		script.push_back(r);
	endfunction

	task automatic send_prim(input prim_t p, input bit fixed, input pick_t fixed_pick);
		int gap;
		pick_t got;
		if (burst_left == 0) begin
			gap = $urandom_range(6);
			if (gap != 0) begin
				prim_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
		end
		prim_ch.valid           <= 1'b1;
		prim_ch.query_x         <= p.query_x;
		prim_ch.query_y         <= p.query_y;
		prim_ch.is_segment      <= p.is_segment;
		prim_ch.on_series_layer <= p.on_series_layer;
		prim_ch.data_index      <= p.data_index;
		prim_ch.ax              <= p.ax;
		prim_ch.ay              <= p.ay;
		prim_ch.bx              <= p.bx;
		prim_ch.by              <= p.by;
		prim_ch.end_of_list     <= p.end_of_list;
		do @(posedge clk); while (!prim_ch.ready);
		burst_left--;
		if (track_nearest(p, got))
			picks_due.push_back(fixed ? fixed_pick : got);
	endtask

	task automatic wait_idle();
		prim_ch.valid <= 1'b0;
		burst_left = 0;
		while (picks_due.size() != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_thr(input logic [npp_pkg::COORD_BITS-1:0] v);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.max_distance <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		thr_now = v;
	endtask

	always @(posedge clk) begin
		if (cycles[9:0] == 10'd0)
			stall_pat <= 11'($urandom) | 11'h1;
		else
			stall_pat <= {stall_pat[0], stall_pat[10:1]};
		if (cycles[11:10] == 2'b00)
			rx_ready <= 1'b1;
		else
			rx_ready <= stall_pat[0];
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && rx_ready) begin
			if (picks_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: hit %0b index %0d",
						res_ch.hit, res_ch.picked_index);
			end else begin
				want_pick = picks_due.pop_front();
				if (res_ch.hit !== want_pick.hit || res_ch.picked_index !== want_pick.idx) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: hit exp %0b got %0b, index exp %0d got %0d",
							want_pick.hit, res_ch.hit, want_pick.idx, res_ch.picked_index);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		prim_t p;
		pick_t fix;
		int thr, span, qx, qy, idx, n, len;

		prim_ch.valid           <= 1'b0;
		prim_ch.query_x         <= '0;
		prim_ch.query_y         <= '0;
		prim_ch.is_segment      <= 1'b0;
		prim_ch.on_series_layer <= 1'b0;
		prim_ch.data_index      <= '0;
		prim_ch.ax              <= '0;
		prim_ch.ay              <= '0;
		prim_ch.bx              <= '0;
		prim_ch.by              <= '0;
		prim_ch.end_of_list     <= 1'b0;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.max_distance     <= '0;

		// threshold from reset: 160
		add_row(-1, 0, 0, 0, 1, 5, 0, 0, 0, 0, 1, 5);
		add_row(-1, 0, 0, 0, 1, 7, 160, 0, 0, 0, 1, -1);
		add_row(-1, 100, -100, 0, 1, 9, 259, -100, 0, 0, 1, 9);
		add_row(-1, 0, 0, 0, 0, 3, 0, 0, 0, 0, 1, -1);
		add_row(-1, 0, 0, 0, 1, -1, 0, 0, 0, 0, 1, -1);
		add_row(-1, 0, 0, 0, 1, -32768, 0, 0, 0, 0, 1, -1);
		add_row(-1, 0, 0, 0, 1, 32767, 0, 0, 0, 0, 1, 32767);
		// tie, earlier primitive wins
		add_row(-1, 500, 500, 0, 1, 11, 530, 500, 0, 0, 0, USE_MODEL);
		add_row(-1, 500, 500, 0, 1, 12, 470, 500, 0, 0, 1, 11);
		// segments: interior, t clamped low, t clamped high, zero length
		add_row(-1, 0, 20, 1, 1, 1, -100, -50, 100, 50, 0, USE_MODEL);
		add_row(-1, 0, 20, 1, 1, 2, 40, 20, 200, 20, 0, USE_MODEL);
		add_row(-1, 0, 20, 1, 1, 3, -300, 20, -10, 20, 0, USE_MODEL);
		add_row(-1, 0, 20, 1, 1, 4, 5, 25, 5, 25, 0, USE_MODEL);
		add_row(-1, 0, 20, 1, 1, 6, -50, 30, 50, 30, 1, USE_MODEL);
		// coordinate extremes
		add_row(-1, -32768, -32768, 0, 1, 100, 32767, 32767, 0, 0, 0, USE_MODEL);
		add_row(-1, 32767, 32767, 1, 1, 101, -32768, 32767, 32767, -32768, 1, USE_MODEL);
		add_row(65535, -32768, -32768, 0, 1, 1, 32767, 32767, 0, 0, 0, USE_MODEL);
		add_row(-1, -32768, -32768, 1, 1, 2, 32767, -32768, -32768, 32767, 1, USE_MODEL);
		add_row(-1, -32768, -32768, 0, 1, 3, 32766, -32768, -1, -1, 1, USE_MODEL);
		// zero threshold
		add_row(0, 0, 0, 0, 1, 4, 0, 0, 0, 0, 1, -1);
		add_row(-1, 0, 0, 1, 1, 4, -16, 0, 16, 0, 1, -1);
		// threshold of one step
		add_row(1, 7, 7, 0, 1, 8, 7, 7, 0, 0, 1, 8);
		add_row(-1, 7, 7, 0, 1, 8, 8, 7, 0, 0, 1, -1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].thr >= 0) begin
				wait_idle();
				write_thr(npp_pkg::COORD_BITS'(script[i].thr));
			end
			fix.hit = script[i].want >= 0;
			fix.idx = npp_pkg::INDEX_BITS'(script[i].want);
			send_prim(script[i].p, script[i].want != USE_MODEL, fix);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: thr = 65535;
				1: thr = 0;
				2: thr = 160;
				3: thr = 1;
				default: thr = $urandom_range(1) ? $urandom_range(2000, 2) : $urandom_range(65535);
			endcase
			wait_idle();
			write_thr(npp_pkg::COORD_BITS'(thr));
			span = (thr > 8000) ? 16000 : 2 * thr + 16;
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				len = $urandom_range(8, 1);
				if ($urandom_range(3) == 0) begin
					qx = $urandom_range(65535);
					qy = $urandom_range(65535);
				end else begin
					qx = int'($urandom_range(8000)) - 4000;
					qy = int'($urandom_range(8000)) - 4000;
				end
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(6) == 0) begin
						p = PRIM_W'({$urandom, $urandom, $urandom, $urandom});
					end else begin
						case ($urandom_range(19))
							0, 1: idx = -1;
							2: idx = -int'($urandom_range(32768, 1));
							default: idx = $urandom_range(32767);
						endcase
						p.is_segment = 1'($urandom_range(1));
						p.on_series_layer = $urandom_range(9) != 0;
						p.data_index = npp_pkg::INDEX_BITS'(idx);
						p.ax = near(qx, span);
						p.ay = near(qy, span);
						p.bx = near(qx, span);
						p.by = near(qy, span);
					end
					p.query_x = npp_pkg::COORD_BITS'(qx);
					p.query_y = npp_pkg::COORD_BITS'(qy);
					p.end_of_list = (k == len - 1);
					send_prim(p, 1'b0, fix);
					n++;
				end
			end
		end

		wait_idle();
		if (mismatches == 0 && picks_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> nearest_primitive_pick_top.f
rtl/core/npp_pkg.sv
rtl/core/npp_in_if.sv
rtl/core/npp_out_if.sv
rtl/core/npp_cfg_if.sv
rtl/core/npp_mac.sv
rtl/core/npp_div.sv
rtl/core/nearest_primitive_pick_top.sv
sim/nearest_primitive_pick_top_test.sv
